// File: src/lfhr_pkg.sv
// Shared constants and types for the length framed history ring.
`timescale 1ns / 1ps
package lfhr_pkg;

  localparam int DEF_STORE_DEPTH = 512;
  localparam int DEF_MAX_CMD_LEN = 64;
  localparam int LEN_W = 7;

  localparam logic [2:0] OP_SAVE_BYTE  = 3'd0;
  localparam logic [2:0] OP_SAVE_EMPTY = 3'd1;
  localparam logic [2:0] OP_PREV       = 3'd2;
  localparam logic [2:0] OP_NEXT       = 3'd3;
  localparam logic [2:0] OP_DELETE     = 3'd4;

  localparam logic [1:0] KIND_BYTE    = 2'd0;
  localparam logic [1:0] KIND_NOTHING = 2'd1;
  localparam logic [1:0] KIND_STORED  = 2'd2;
  localparam logic [1:0] KIND_SKIPPED = 2'd3;

  typedef struct packed {
    logic push;
    logic clear;
  } stg_ctl_t;

endpackage

// File: src/length_framed_history_ring.sv
// Top level: record store, command sequencer and result register.
//
// Command history ring. One command word enters at a rising edge with start
// high and busy low: opcode, data_byte and last_byte. Save byte words with
// last_byte low and words with an unknown opcode give no result and leave
// busy low. Every other word keeps busy high until its work is done and then
// gives one or more results, each shown for exactly one cycle with strobe
// high; last_of_run marks the final one. The receiver cannot stall, so
// results are never held.
// A stream steps through each record byte, a save compare through each byte,
// an append through each stored byte and a delete through each byte moved
// behind the removed record. All of it is set by the record store, which has
// one read and one write port and a registered read, so each step handles one
// byte. The staging line has its own memory and is read alongside the store.
// After reset busy stays high while the first two store bytes
// are cleared to form the empty starting record.
module length_framed_history_ring
  import lfhr_pkg::*;
#(
  parameter int STORE_DEPTH = DEF_STORE_DEPTH,
  parameter int MAX_CMD_LEN = DEF_MAX_CMD_LEN
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [2:0]       opcode,
  input  logic [7:0]       data_byte,
  input  logic             last_byte,
  output logic             strobe,
  output logic [1:0]       kind,
  output logic [7:0]       out_byte,
  output logic [LEN_W-1:0] record_length,
  output logic             last_of_run
);

  localparam int PW = $clog2(STORE_DEPTH);
  localparam logic [LEN_W-1:0] MAXL = LEN_W'(MAX_CMD_LEN);

  localparam logic [4:0] S_INIT0 = 5'd0;
  localparam logic [4:0] S_INIT1 = 5'd1;
  localparam logic [4:0] S_IDLE  = 5'd2;
  localparam logic [4:0] S_SV_A  = 5'd3;
  localparam logic [4:0] S_SV_B  = 5'd4;
  localparam logic [4:0] S_CM_A  = 5'd5;
  localparam logic [4:0] S_CM_B  = 5'd6;
  localparam logic [4:0] S_CR_A  = 5'd7;
  localparam logic [4:0] S_CR_B  = 5'd8;
  localparam logic [4:0] S_PT_A  = 5'd9;
  localparam logic [4:0] S_PT_B  = 5'd10;
  localparam logic [4:0] S_PV_A  = 5'd11;
  localparam logic [4:0] S_PV_B  = 5'd12;
  localparam logic [4:0] S_NX_A  = 5'd13;
  localparam logic [4:0] S_NX_B  = 5'd14;
  localparam logic [4:0] S_DL_A  = 5'd15;
  localparam logic [4:0] S_DL_B  = 5'd16;
  localparam logic [4:0] S_DL_C  = 5'd17;
  localparam logic [4:0] S_DL_D  = 5'd18;
  localparam logic [4:0] S_DL_E  = 5'd19;
  localparam logic [4:0] S_DL_G  = 5'd20;
  localparam logic [4:0] S_DL_F  = 5'd21;
  localparam logic [4:0] S_ST_A  = 5'd22;
  localparam logic [4:0] S_ST_B  = 5'd23;
  localparam logic [4:0] S_ST_C  = 5'd24;
  localparam logic [4:0] S_ST_D  = 5'd25;
  localparam logic [4:0] S_NONE  = 5'd26;

  logic [4:0]       state;
  logic [PW-1:0]    free_pos;
  logic [PW-1:0]    oldest;
  logic [PW-1:0]    cur;
  logic             moved_fwd;
  logic [PW-1:0]    wp;
  logic [PW-1:0]    src;
  logic [PW-1:0]    dst;
  logic [PW-1:0]    span;
  logic             again;
  logic [LEN_W-1:0] len;
  logic [LEN_W-1:0] idx;

  logic [7:0]    store_mem [STORE_DEPTH];
  logic [7:0]    ram_rdata;
  logic [PW-1:0] ram_raddr;
  logic [PW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic          ram_we;

  stg_ctl_t         stg_ctl;
  logic [LEN_W-1:0] stg_idx;
  logic [7:0]       stg_rdata;
  logic [LEN_W-1:0] stg_count;

  logic             accept;
  logic [PW-1:0]    rd_pos;
  logic [PW-1:0]    back_pos;
  logic [PW-1:0]    fwd_pos;
  logic [LEN_W-1:0] clamped;

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign rd_pos  = PW'(ram_rdata);
  assign back_pos = wp - rd_pos - PW'(2);
  assign fwd_pos  = wp + rd_pos + PW'(2);
  assign clamped = (ram_rdata > 8'(MAX_CMD_LEN)) ? MAXL : ram_rdata[LEN_W-1:0];

  assign stg_ctl.push  = accept && opcode == OP_SAVE_BYTE;
  assign stg_ctl.clear = accept && ((opcode == OP_SAVE_BYTE && last_byte)
                                    || opcode == OP_SAVE_EMPTY);
  assign stg_idx = (state == S_PT_A) ? idx - 1'b1 : idx;

  lfhr_stage #(
    .MAX_CMD_LEN(MAX_CMD_LEN)
  ) u_stage (
    .clk     (clk),
    .rst     (rst),
    .ctl     (stg_ctl),
    .wr_byte (data_byte),
    .rd_idx  (stg_idx),
    .rd_data (stg_rdata),
    .count   (stg_count)
  );

  // Store address and write selection per sequencer step.
  always_comb begin
    ram_raddr = wp;
    ram_we    = 1'b0;
    ram_waddr = free_pos;
    ram_wdata = '0;
    unique case (state)
      S_INIT0: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
      end
      S_INIT1: begin
        ram_we    = 1'b1;
        ram_waddr = PW'(1);
      end
      S_SV_A:  ram_raddr = free_pos - 1'b1;
      S_CM_A:  ram_raddr = cur;
      S_CR_A:  ram_raddr = cur + PW'(idx) + 1'b1;
      S_PT_A:  ram_raddr = oldest;
      S_PT_B: begin
        ram_we    = 1'b1;
        ram_waddr = free_pos;
        ram_wdata = (idx == '0 || idx == len + 1'b1) ? 8'(len) : stg_rdata;
      end
      S_PV_A:  ram_raddr = wp - 1'b1;
      S_DL_E:  ram_raddr = src;
      S_DL_G: begin
        ram_we    = 1'b1;
        ram_waddr = dst;
        ram_wdata = ram_rdata;
      end
      S_ST_C:  ram_raddr = wp + PW'(idx);
      default: ram_raddr = wp;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      store_mem[ram_waddr] <= ram_wdata;
    end
    ram_rdata <= store_mem[ram_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT0;
      free_pos  <= PW'(2);
      oldest    <= '0;
      cur       <= '0;
      moved_fwd <= 1'b0;
      strobe    <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        S_INIT0: state <= S_INIT1;
        S_INIT1: state <= S_IDLE;
        S_IDLE: begin
          if (start) begin
            wp <= cur;
            unique case (opcode)
              OP_SAVE_BYTE: begin
                if (last_byte) begin
                  len   <= (stg_count < MAXL) ? stg_count + 1'b1 : stg_count;
                  state <= S_SV_A;
                end
              end
              OP_SAVE_EMPTY: begin
                len   <= '0;
                state <= S_SV_A;
              end
              OP_PREV: begin
                if (cur == oldest) begin
                  moved_fwd <= 1'b1;
                  state     <= S_NONE;
                end else begin
                  again <= moved_fwd;
                  state <= S_PV_A;
                end
              end
              OP_NEXT: begin
                again <= !moved_fwd;
                state <= S_NX_A;
              end
              OP_DELETE: state <= moved_fwd ? S_DL_C : S_DL_A;
              default:   state <= S_IDLE;
            endcase
          end
        end
        S_SV_A: state <= S_SV_B;
        S_SV_B: begin
          cur       <= free_pos - rd_pos - PW'(2);
          moved_fwd <= 1'b0;
          if (len == '0) begin
            strobe        <= 1'b1;
            kind          <= KIND_SKIPPED;
            out_byte      <= '0;
            record_length <= '0;
            last_of_run   <= 1'b1;
            state         <= S_IDLE;
          end else begin
            state <= S_CM_A;
          end
        end
        S_CM_A: state <= S_CM_B;
        S_CM_B: begin
          idx <= '0;
          if (ram_rdata != 8'(len)) begin
            cur   <= free_pos;
            state <= S_PT_A;
          end else begin
            state <= S_CR_A;
          end
        end
        S_CR_A: state <= S_CR_B;
        S_CR_B: begin
          if (ram_rdata != stg_rdata) begin
            cur   <= free_pos;
            idx   <= '0;
            state <= S_PT_A;
          end else if (idx + 1'b1 == len) begin
            strobe        <= 1'b1;
            kind          <= KIND_SKIPPED;
            out_byte      <= '0;
            record_length <= len;
            last_of_run   <= 1'b1;
            state         <= S_IDLE;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_CR_A;
          end
        end
        S_PT_A: state <= S_PT_B;
        S_PT_B: begin
          // Writing over the oldest record's length byte evicts that record.
          if (free_pos == oldest) begin
            oldest <= oldest + rd_pos + PW'(2);
          end
          free_pos <= free_pos + 1'b1;
          if (idx == len + 1'b1) begin
            strobe        <= 1'b1;
            kind          <= KIND_STORED;
            out_byte      <= '0;
            record_length <= len;
            last_of_run   <= 1'b1;
            state         <= S_IDLE;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_PT_A;
          end
        end
        S_PV_A: state <= S_PV_B;
        S_PV_B: begin
          cur <= back_pos;
          if (again) begin
            if (back_pos == oldest) begin
              state <= S_NONE;
            end else begin
              wp    <= back_pos;
              again <= 1'b0;
              state <= S_PV_A;
            end
          end else begin
            moved_fwd <= 1'b0;
            state     <= S_ST_A;
          end
        end
        S_NX_A: state <= S_NX_B;
        S_NX_B: begin
          if (again) begin
            if (fwd_pos == free_pos) begin
              state <= S_NONE;
            end else begin
              cur   <= fwd_pos;
              wp    <= fwd_pos;
              again <= 1'b0;
              state <= S_NX_A;
            end
          end else if (fwd_pos == free_pos) begin
            moved_fwd <= 1'b0;
            state     <= S_NONE;
          end else begin
            moved_fwd <= 1'b1;
            cur       <= fwd_pos;
            wp        <= fwd_pos;
            state     <= S_ST_A;
          end
        end
        S_DL_A: state <= S_DL_B;
        S_DL_B: begin
          wp    <= fwd_pos;
          state <= S_DL_C;
        end
        S_DL_C: begin
          if (wp == free_pos) begin
            state <= S_NONE;
          end else begin
            cur   <= wp;
            state <= S_DL_D;
          end
        end
        S_DL_D: begin
          span  <= rd_pos + PW'(2);
          src   <= fwd_pos;
          dst   <= wp;
          state <= S_DL_E;
        end
        S_DL_E: begin
          if (src == free_pos) begin
            free_pos  <= free_pos - span;
            moved_fwd <= 1'b1;
            state     <= S_DL_F;
          end else begin
            state <= S_DL_G;
          end
        end
        S_DL_G: begin
          dst   <= dst + 1'b1;
          src   <= src + 1'b1;
          state <= S_DL_E;
        end
        S_DL_F: state <= (cur == free_pos) ? S_NONE : S_ST_A;
        S_ST_A: state <= S_ST_B;
        S_ST_B: begin
          if (clamped == '0) begin
            state <= S_NONE;
          end else begin
            len   <= clamped;
            idx   <= LEN_W'(1);
            state <= S_ST_C;
          end
        end
        S_ST_C: state <= S_ST_D;
        S_ST_D: begin
          strobe        <= 1'b1;
          kind          <= KIND_BYTE;
          out_byte      <= ram_rdata;
          record_length <= len;
          last_of_run   <= (idx == len);
          if (idx == len) begin
            state <= S_IDLE;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_ST_C;
          end
        end
        S_NONE: begin
          strobe        <= 1'b1;
          kind          <= KIND_NOTHING;
          out_byte      <= '0;
          record_length <= '0;
          last_of_run   <= 1'b1;
          state         <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_nothing_ends_run: assert property (@(posedge clk) disable iff (rst)
    strobe && kind == KIND_NOTHING |-> last_of_run && record_length == '0)
    else $error("nothing result must be a single final word");

  a_length_bound: assert property (@(posedge clk) disable iff (rst)
    strobe |-> record_length <= MAXL)
    else $error("record length beyond the command limit");

  a_byte_nonzero_len: assert property (@(posedge clk) disable iff (rst)
    strobe && kind == KIND_BYTE |-> record_length != '0)
    else $error("record byte with zero length");

  a_final_frees_busy: assert property (@(posedge clk) disable iff (rst)
    strobe && last_of_run |-> !busy)
    else $error("final word shown while still busy");

  a_reset_busy: assert property (@(posedge clk)
    $past(rst) && !rst |-> busy)
    else $error("block must clear the store head after reset");

endmodule

// File: src/lfhr_stage.sv
// Staging line memory and fill count for the command being saved.
`timescale 1ns / 1ps
module lfhr_stage
  import lfhr_pkg::*;
#(
  parameter int MAX_CMD_LEN = DEF_MAX_CMD_LEN
) (
  input  logic             clk,
  input  logic             rst,
  input  stg_ctl_t         ctl,
  input  logic [7:0]       wr_byte,
  input  logic [LEN_W-1:0] rd_idx,
  output logic [7:0]       rd_data,
  output logic [LEN_W-1:0] count
);

  localparam int IW = (MAX_CMD_LEN > 1) ? $clog2(MAX_CMD_LEN) : 1;

  logic [7:0] line_mem [MAX_CMD_LEN];

  // Bytes beyond the line length are dropped.
  always_ff @(posedge clk) begin
    if (ctl.push && count < LEN_W'(MAX_CMD_LEN)) begin
      line_mem[count[IW-1:0]] <= wr_byte;
    end
    rd_data <= line_mem[rd_idx[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.clear) begin
      count <= '0;
    end else if (ctl.push && count < LEN_W'(MAX_CMD_LEN)) begin
      count <= count + 1'b1;
    end
  end

endmodule
